/* design/cycle_count_to_nanoseconds_assert.svh */
// Assertion macros shared by the cycle count to nanoseconds design.
// Used by the top level; expects clk and rst_n in scope.
`ifndef CYCLE_COUNT_TO_NANOSECONDS_ASSERT_SVH
`define CYCLE_COUNT_TO_NANOSECONDS_ASSERT_SVH

// Check a property outside reset.
`define C2N_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define C2N_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/cc2ns_pkg.sv */
// Types and constants for the cycle count to nanoseconds scaler.
// No dependencies.
`default_nettype none
package cc2ns_pkg;

  localparam int unsigned DIV_STAGES = 64;
  // Reciprocal of 625 for the divide by 10000 (= 16 * 625): ceil(2^70 / 625)
  localparam logic [60:0] FRAC_MAGIC = 61'd1888946593147858086;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_RATIO_NSEC  = 3'd0,
    REG_RATIO_FREQ  = 3'd1,
    REG_SPLIT_SHIFT = 3'd2,
    REG_WHOLE_NS    = 3'd3,
    REG_FRACTION    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [29:0] ratio_nsec;
    logic [31:0] ratio_freq;
    logic [5:0]  split_shift;
    logic [63:0] whole_ns_per_split;
    logic [13:0] fraction_per_split;
  } cfg_t;

  // Operands handed from the multiply stages to the dividers and the whole-term delay line
  typedef struct packed {
    logic [63:0] scaled;     // count part times ratio_nsec
    logic [63:0] whole;      // high part times whole ns per block
    logic [63:0] frac;       // high part times fraction
  } prod_t;

endpackage
`default_nettype wire

/* design/cc2ns_mul.sv */
// Split decode and two-stage 64-bit modular products.
// Depends on cc2ns_pkg.
`default_nettype none
module cc2ns_mul (
  input  wire                  clk,
  input  wire                  en,
  input  wire [63:0]           cnt,
  input  wire cc2ns_pkg::cfg_t cfg,
  output cc2ns_pkg::prod_t     prod
);
  import cc2ns_pkg::*;

  logic [63:0] limit, hi, lo, x;
  logic        split;
  logic [61:0] pn_lo_r, pn_lo_nxt;
  logic [31:0] pn_hi_r, pn_hi_nxt;
  logic [63:0] pw_ll_r, pw_ll_nxt;
  logic [31:0] pw_lh_r, pw_lh_nxt, pw_hl_r, pw_hl_nxt;
  logic [45:0] pf_l_r, pf_l_nxt;
  logic [31:0] pf_h_r, pf_h_nxt;
  logic [63:0] pw_lh_full, pw_hl_full, pn_hi_full;
  logic [45:0] pf_h_full;
  prod_t       prod_r, prod_nxt;

  // Cut the count at the split point; a count at or below it scales whole
  always_comb begin
    limit = 64'd1 << cfg.split_shift;
    split = cnt > limit;
    hi    = split ? (cnt >> cfg.split_shift) : 64'd0;
    lo    = cnt & (limit - 64'd1);
    x     = split ? lo : cnt;
  end

  // Partial products, 32-bit halves
  always_comb begin
    pn_lo_nxt  = 62'(x[31:0]) * 62'(cfg.ratio_nsec);
    pn_hi_full = 64'(x[63:32]) * 64'(cfg.ratio_nsec);
    pn_hi_nxt  = pn_hi_full[31:0];
    pw_ll_nxt  = 64'(cfg.whole_ns_per_split[31:0]) * 64'(hi[31:0]);
    pw_lh_full = 64'(cfg.whole_ns_per_split[31:0]) * 64'(hi[63:32]);
    pw_hl_full = 64'(cfg.whole_ns_per_split[63:32]) * 64'(hi[31:0]);
    pw_lh_nxt  = pw_lh_full[31:0];
    pw_hl_nxt  = pw_hl_full[31:0];
    pf_l_nxt   = 46'(hi[31:0]) * 46'(cfg.fraction_per_split);
    pf_h_full  = 46'(hi[63:32]) * 46'(cfg.fraction_per_split);
    pf_h_nxt   = pf_h_full[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pn_lo_r <= pn_lo_nxt;
      pn_hi_r <= pn_hi_nxt;
      pw_ll_r <= pw_ll_nxt;
      pw_lh_r <= pw_lh_nxt;
      pw_hl_r <= pw_hl_nxt;
      pf_l_r  <= pf_l_nxt;
      pf_h_r  <= pf_h_nxt;
    end
  end

  // Recombine halves modulo 2^64
  always_comb begin
    prod_nxt.scaled = 64'(pn_lo_r) + {pn_hi_r, 32'd0};
    prod_nxt.whole  = pw_ll_r + {pw_lh_r + pw_hl_r, 32'd0};
    prod_nxt.frac   = 64'(pf_l_r) + {pf_h_r, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

/* design/cc2ns_div.sv */
// Pipelined dividers: a restoring 64-by-32-bit divider with one quotient bit
// per stage (zero divisor yields all ones), and a divide by 10000 done as a
// reciprocal multiply padded to the same depth. Uses cc2ns_pkg.
`default_nettype none
module cc2ns_div (
  input  wire        clk,
  input  wire        en,
  input  wire [63:0] num,
  input  wire [31:0] den,
  output logic [63:0] quot
);
  import cc2ns_pkg::*;

  logic [31:0] rem_r [DIV_STAGES];
  logic [63:0] w_r   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [31:0] rem_p;
    logic [63:0] w_p;
    logic [32:0] tmp;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_p = 32'd0;
      assign w_p   = num;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign w_p   = w_r[k-1];
    end

    // Shift in the next dividend bit and try the subtract
    assign tmp = {rem_p, w_p[63]};
    assign ge  = tmp >= {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? 32'(tmp - {1'b0, den}) : tmp[31:0];
        w_r[k]   <= {w_p[62:0], ge};
      end
    end
  end

  assign quot = w_r[DIV_STAGES-1];

endmodule

// Divide by 10000 padded to the register depth of cc2ns_div: drop the factor 16,
// multiply by the reciprocal of 625 in 32-bit pieces, sum, then delay.
module cc2ns_div_frac (
  input  wire        clk,
  input  wire        en,
  input  wire [63:0] num,
  output logic [63:0] quot
);
  import cc2ns_pkg::*;

  localparam int unsigned QDEPTH = DIV_STAGES - 2;

  logic [59:0]  n;
  logic [63:0]  p0_r, p0_nxt;
  logic [60:0]  p1_r, p1_nxt;
  logic [59:0]  p2_r, p2_nxt;
  logic [56:0]  p3_r, p3_nxt;
  logic [63:0]  p0_q_r;
  logic [56:0]  p3_q_r;
  logic [61:0]  mid_r, mid_nxt;
  logic [120:0] sum;
  logic [50:0]  q_nxt;
  logic [50:0]  q_r [QDEPTH];

  // Partial products of (num / 16) times the reciprocal
  assign n = num[63:4];
  always_comb begin
    p0_nxt = 64'(n[31:0]) * 64'(FRAC_MAGIC[31:0]);
    p1_nxt = 61'(n[31:0]) * 61'(FRAC_MAGIC[60:32]);
    p2_nxt = 60'(n[59:32]) * 60'(FRAC_MAGIC[31:0]);
    p3_nxt = 57'(n[59:32]) * 57'(FRAC_MAGIC[60:32]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      p3_r <= p3_nxt;
    end
  end

  // Add the cross terms
  assign mid_nxt = 62'(p1_r) + 62'(p2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      mid_r  <= mid_nxt;
      p0_q_r <= p0_r;
      p3_q_r <= p3_r;
    end
  end

  // Full product, quotient is the top bits above 2^70
  assign sum   = 121'(p0_q_r) + {27'd0, mid_r, 32'd0} + {p3_q_r, 64'd0};
  assign q_nxt = sum[120:70];

  // Hold the quotient until the ratio divider catches up
  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0] <= q_nxt;
      for (int i = 1; i < QDEPTH; i++) begin
        q_r[i] <= q_r[i-1];
      end
    end
  end

  assign quot = {13'd0, q_r[QDEPTH-1]};

endmodule
`default_nettype wire

/* design/cycle_count_to_nanoseconds.sv */
// An accepted input reaches out_tvalid through the input register, two
// multiply stages, 64 divider stages and the output register.
// The divide by 10000 is a reciprocal multiply padded to the divider depth.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and out_tready is low.
// Reset (rst_n low, synchronous) clears all valid bits and loads defaults.
`default_nettype none
module cycle_count_to_nanoseconds (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [63:0]  in_tdata,    // [63:0] cycle_count
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,   // [63:0] nanoseconds
  input  wire         cfg_we,
  input  wire [2:0]   cfg_addr,
  input  wire [63:0]  cfg_wdata
);
  import cc2ns_pkg::*;
  `include "cycle_count_to_nanoseconds_assert.svh"

  localparam int unsigned VDEPTH = 3 + DIV_STAGES;

  cfg_t        cfg_r;
  logic        en;
  logic [VDEPTH-1:0] v_r;
  logic [63:0] cnt_r;
  prod_t       prod;
  logic [63:0] a_r [DIV_STAGES];
  logic [63:0] qb, qc;
  logic        out_valid_r;
  logic [63:0] out_data_r, out_data_nxt;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ratio_nsec         <= 30'd1;
      cfg_r.ratio_freq         <= 32'd1;
      cfg_r.split_shift        <= 6'd63;
      cfg_r.whole_ns_per_split <= 64'h8000_0000_0000_0000;
      cfg_r.fraction_per_split <= 14'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RATIO_NSEC:  cfg_r.ratio_nsec         <= cfg_wdata[29:0];
        REG_RATIO_FREQ:  cfg_r.ratio_freq         <= cfg_wdata[31:0];
        REG_SPLIT_SHIFT: cfg_r.split_shift        <= cfg_wdata[5:0];
        REG_WHOLE_NS:    cfg_r.whole_ns_per_split <= cfg_wdata;
        REG_FRACTION:    cfg_r.fraction_per_split <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  // Advance everything unless a finished result is waiting and out_tready is low
  assign en        = out_tready || !out_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[VDEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt_r <= in_tdata;
    end
  end

  cc2ns_mul u_mul (
    .clk  (clk),
    .en   (en),
    .cnt  (cnt_r),
    .cfg  (cfg_r),
    .prod (prod)
  );

  cc2ns_div u_div_ratio (
    .clk  (clk),
    .en   (en),
    .num  (prod.scaled),
    .den  (cfg_r.ratio_freq),
    .quot (qb)
  );

  cc2ns_div_frac u_div_frac (
    .clk  (clk),
    .en   (en),
    .num  (prod.frac),
    .quot (qc)
  );

  // Carry the whole-block term alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0] <= prod.whole;
      for (int i = 1; i < DIV_STAGES; i++) begin
        a_r[i] <= a_r[i-1];
      end
    end
  end

  assign out_data_nxt = a_r[DIV_STAGES-1] + qb + qc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[VDEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `C2N_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid_r && v_r == '0,
    "reset left items in flight")
  `C2N_ASSERT(a_accept_enters, in_tvalid && in_tready |=> v_r[0],
    "accepted transfer did not enter the pipeline")
  `C2N_ASSERT(a_hold_on_stall, !en |=> $stable(v_r) && $stable(out_data_r),
    "pipeline moved while stalled")

endmodule
`default_nettype wire
